@@ src/imuoci_pkg.sv @@
`default_nettype none
package imuoci_pkg;

    // Parameter defaults
    localparam int CHANNELS_DEF       = 6;
    localparam int ACCEL_CHANNELS_DEF = 3;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int COUNT_BITS_DEF     = 16;

    // Fixed field widths
    localparam int SAMPLE_W      = 16;
    localparam int SAMPLE_FIELDS = 6;
    localparam int VAL_W         = 48;
    localparam int CHAN_W        = 3;
    localparam int GAIN_W        = 24;
    localparam int DECAY_W       = 17;
    localparam int CALIB_W       = 16;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int SUM_W         = 32;

    // Shared multiplier: signed A times unsigned B, value split in two halves
    localparam int SPLIT   = VAL_W / 2;
    localparam int MUL_A_W = SPLIT + 1;
    localparam int MUL_B_W = GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
    localparam int ACC_W   = 72;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(65536);
    localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(65536);
    localparam logic [CALIB_W-1:0] CALIB_RST = CALIB_W'(64);

    typedef enum logic [1:0] {
        MODE_SAMPLE    = 2'd0,
        MODE_CLR_VEL   = 2'd1,
        MODE_CLR_DIST  = 2'd2,
        MODE_CAL_START = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_GAIN    = 3'd0,
        REG_GYRO_GAIN     = 3'd1,
        REG_VEL_DECAY     = 3'd2,
        REG_DIST_DECAY    = 3'd3,
        REG_CALIB_SAMPLES = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_mode                       mode;
        logic signed [SAMPLE_W-1:0]  sample_ax;
        logic signed [SAMPLE_W-1:0]  sample_ay;
        logic signed [SAMPLE_W-1:0]  sample_az;
        logic signed [SAMPLE_W-1:0]  sample_gx;
        logic signed [SAMPLE_W-1:0]  sample_gy;
        logic signed [SAMPLE_W-1:0]  sample_gz;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0]        channel;
        logic signed [VAL_W-1:0]  accel_value;
        logic signed [VAL_W-1:0]  vel_value;
        logic signed [VAL_W-1:0]  dist_value;
        logic                     last;
    } t_out;

    // Clamp a wide signed sum to the value range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] x);
        logic signed [VAL_W-1:0] r;
        if (x[ACC_W-1:VAL_W-1] == '0 || x[ACC_W-1:VAL_W-1] == '1) begin
            r = x[VAL_W-1:0];
        end else if (x[ACC_W-1]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/imuoci_div.sv @@
`default_nettype none
module imuoci_div #(
    parameter int COUNT_BITS = imuoci_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [imuoci_pkg::SUM_W-1:0]  i_dividend,
    input  wire logic [COUNT_BITS-1:0]         i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [imuoci_pkg::SUM_W-1:0]       o_quotient
);
    import imuoci_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [SUM_W-1:0]      r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [COUNT_BITS:0]   rem_sh;
    logic [COUNT_BITS:0]   rem_sub;
    logic                  fits;

    // One restoring step per cycle, quotient bits shift in from the bottom
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == STEP_W'(SUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

@@ src/imu_offset_calibrate_integrate_unit.sv @@
`default_nettype none
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data   (imuoci_pkg::t_in)
// output    out        o_out_valid / i_out_stall o_out_data  (imuoci_pkg::t_out)
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A sample request runs each channel in turn on the shared multiplier (one gain product,
// two partial products per leaky integrator, two add steps each). The sample that closes
// a calibration run also runs the serial divider for each channel. Control requests
// (clear, start calibration) are handled in the idle state.
// Reset is synchronous: gains, decays, offsets, sums and integrators return to defaults.
// A stalled output holds the sequencer at the end of a channel; the input stays stalled
// until the whole request is done.
module imu_offset_calibrate_integrate_unit #(
    parameter int CHANNELS       = imuoci_pkg::CHANNELS_DEF,
    parameter int ACCEL_CHANNELS = imuoci_pkg::ACCEL_CHANNELS_DEF,
    parameter int FRAC_BITS      = imuoci_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS     = imuoci_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire imuoci_pkg::t_in                   i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output imuoci_pkg::t_out                       o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [imuoci_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [imuoci_pkg::CFG_W-1:0]      i_cfg_data
);
    import imuoci_pkg::*;

    localparam int CW = $clog2(CHANNELS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_VLO,
        S_VHI,
        S_VADD,
        S_VNEW,
        S_DLO,
        S_DHI,
        S_DADD,
        S_DNEW,
        S_DIV
    } t_state;

    // Configuration
    logic [GAIN_W-1:0]  r_accel_gain;
    logic [GAIN_W-1:0]  r_gyro_gain;
    logic [DECAY_W-1:0] r_vel_decay;
    logic [DECAY_W-1:0] r_dist_decay;
    logic [CALIB_W-1:0] r_calib_samples;

    // Per-channel state
    logic signed [SAMPLE_W-1:0] r_offset  [CHANNELS];
    logic [SUM_W-1:0]           r_cal_sum [CHANNELS];
    logic signed [VAL_W-1:0]    r_vel     [CHANNELS];
    logic signed [VAL_W-1:0]    r_dist    [CHANNELS];

    logic                  r_cal_run;
    logic [COUNT_BITS-1:0] r_cal_cnt;
    logic [COUNT_BITS-1:0] r_cal_len;

    // Sequencer
    t_state         r_state;
    logic [CW-1:0]  r_ch;
    logic           r_out_valid;
    t_out           r_out;

    // Datapath
    t_in                        r_in;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_sum;
    logic signed [VAL_W-1:0]    r_accv;
    logic                       r_div_neg;

    logic                        in_acc;
    logic                        out_free;
    logic                        last_ch;
    logic                        cal_add;
    logic                        cal_fin;
    logic                        ch_done;
    logic [COUNT_BITS-1:0]       cal_n;
    logic signed [SAMPLE_W-1:0]  fields [SAMPLE_FIELDS];
    logic signed [SAMPLE_W-1:0]  samp;
    logic signed [SAMPLE_W:0]    raw;
    logic [GAIN_W-1:0]           gain;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic signed [MUL_A_W-1:0]   mul_bs;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [VAL_W-1:0]     addend;
    logic signed [ACC_W-1:0]     leak_sum;
    logic signed [VAL_W-1:0]     new_val;
    logic signed [SUM_W-1:0]     sum_s;
    logic [SUM_W-1:0]            div_mag;
    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic [SUM_W-1:0]            div_quo;
    logic [SUM_W-1:0]            div_res;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_ch    = (r_ch == CW'(CHANNELS - 1));
    assign cal_add    = r_cal_run && (r_cal_cnt != '0);
    assign cal_fin    = r_cal_run && (r_cal_cnt == '0);

    always_comb begin
        cal_n = COUNT_BITS'(r_calib_samples);
        if (cal_n == '0) begin
            cal_n = COUNT_BITS'(1);
        end
    end

    assign fields[0] = r_in.sample_ax;
    assign fields[1] = r_in.sample_ay;
    assign fields[2] = r_in.sample_az;
    assign fields[3] = r_in.sample_gx;
    assign fields[4] = r_in.sample_gy;
    assign fields[5] = r_in.sample_gz;

    // Channels past the sample fields read zero
    always_comb begin
        samp = '0;
        for (int i = 0; i < SAMPLE_FIELDS; i++) begin
            if (i < CHANNELS && r_ch == CW'(i)) begin
                samp = fields[i];
            end
        end
    end

    assign raw  = (SAMPLE_W + 1)'(samp) - (SAMPLE_W + 1)'(r_offset[r_ch]);
    assign gain = (32'(r_ch) < ACCEL_CHANNELS) ? r_accel_gain : r_gyro_gain;

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_ACC: begin
                mul_a = MUL_A_W'(raw);
                mul_b = gain;
            end
            S_VLO: begin
                mul_a = $signed({1'b0, r_vel[r_ch][SPLIT-1:0]});
                mul_b = MUL_B_W'(r_vel_decay);
            end
            S_VHI: begin
                mul_a = MUL_A_W'($signed(r_vel[r_ch][VAL_W-1:SPLIT]));
                mul_b = MUL_B_W'(r_vel_decay);
            end
            S_DLO: begin
                mul_a = $signed({1'b0, r_dist[r_ch][SPLIT-1:0]});
                mul_b = MUL_B_W'(r_dist_decay);
            end
            S_DHI: begin
                mul_a = MUL_A_W'($signed(r_dist[r_ch][VAL_W-1:SPLIT]));
                mul_b = MUL_B_W'(r_dist_decay);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_bs = $signed({1'b0, mul_b});
    assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_bs);

    // Leaky update: floor(old * decay / 2^FRAC_BITS) plus input, clamped
    assign addend   = (r_state == S_VNEW) ? r_accv : r_vel[r_ch];
    assign leak_sum = (r_sum >>> FRAC_BITS) + ACC_W'(addend);
    assign new_val  = sat_val(leak_sum);

    assign ch_done  = (r_state == S_DNEW && out_free && !cal_fin)
                   || (r_state == S_DIV && div_done);

    assign sum_s     = $signed(r_cal_sum[r_ch]);
    assign div_mag   = sum_s[SUM_W-1] ? SUM_W'(-sum_s) : SUM_W'(sum_s);
    assign div_start = (r_state == S_DNEW) && out_free && cal_fin;
    assign div_res   = r_div_neg ? (SUM_W'(0) - div_quo) : div_quo;

    imuoci_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (r_cal_len),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_gain    <= GAIN_RST;
            r_gyro_gain     <= GAIN_RST;
            r_vel_decay     <= DECAY_RST;
            r_dist_decay    <= DECAY_RST;
            r_calib_samples <= CALIB_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACCEL_GAIN:    r_accel_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_GYRO_GAIN:     r_gyro_gain     <= i_cfg_data[GAIN_W-1:0];
                REG_VEL_DECAY:     r_vel_decay     <= i_cfg_data[DECAY_W-1:0];
                REG_DIST_DECAY:    r_dist_decay    <= i_cfg_data[DECAY_W-1:0];
                REG_CALIB_SAMPLES: r_calib_samples <= i_cfg_data[CALIB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            r_cal_run   <= 1'b0;
            r_cal_cnt   <= '0;
            r_cal_len   <= COUNT_BITS'(1);
            for (int i = 0; i < CHANNELS; i++) begin
                r_offset[i]  <= '0;
                r_cal_sum[i] <= '0;
                r_vel[i]     <= '0;
                r_dist[i]    <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && !(r_state == S_DNEW && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.mode)
                            MODE_SAMPLE: begin
                                r_ch    <= '0;
                                r_state <= S_ACC;
                            end
                            MODE_CLR_VEL: begin
                                for (int i = 0; i < CHANNELS; i++) begin
                                    r_vel[i] <= '0;
                                end
                            end
                            MODE_CLR_DIST: begin
                                for (int i = 0; i < CHANNELS; i++) begin
                                    r_dist[i] <= '0;
                                end
                            end
                            MODE_CAL_START: begin
                                r_cal_run <= 1'b1;
                                r_cal_cnt <= cal_n;
                                r_cal_len <= cal_n;
                                for (int i = 0; i < CHANNELS; i++) begin
                                    r_cal_sum[i] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ACC:  r_state <= S_VLO;
                S_VLO:  r_state <= S_VHI;
                S_VHI:  r_state <= S_VADD;
                S_VADD: r_state <= S_VNEW;
                S_VNEW: begin
                    r_vel[r_ch] <= new_val;
                    r_state     <= S_DLO;
                end
                S_DLO:  r_state <= S_DHI;
                S_DHI:  r_state <= S_DADD;
                S_DADD: r_state <= S_DNEW;
                S_DNEW: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        r_dist[r_ch]      <= new_val;
                        r_out_valid       <= 1'b1;
                        r_out.channel     <= CHAN_W'(r_ch);
                        r_out.accel_value <= r_accv;
                        r_out.vel_value   <= r_vel[r_ch];
                        r_out.dist_value  <= new_val;
                        r_out.last        <= last_ch;
                        if (cal_add) begin
                            r_cal_sum[r_ch] <= r_cal_sum[r_ch] + SUM_W'(samp);
                        end
                        if (cal_fin) begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_offset[r_ch] <= div_res[SAMPLE_W-1:0];
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // advance to the next channel or close out the request
            if (ch_done) begin
                if (last_ch) begin
                    r_state <= S_IDLE;
                    if (cal_add) begin
                        r_cal_cnt <= r_cal_cnt - COUNT_BITS'(1);
                    end else if (cal_fin) begin
                        r_cal_run <= 1'b0;
                    end
                end else begin
                    r_ch    <= r_ch + CW'(1);
                    r_state <= S_ACC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        case (r_state)
            S_ACC: r_prod <= mul_p;
            S_VLO: begin
                r_accv <= r_prod[VAL_W-1:0];
                r_prod <= mul_p;
            end
            S_VHI, S_DHI: begin
                r_sum  <= ACC_W'(r_prod);
                r_prod <= mul_p;
            end
            S_DLO: r_prod <= mul_p;
            S_VADD, S_DADD: r_sum <= r_sum + (ACC_W'(r_prod) <<< SPLIT);
            default: ;
        endcase
        if (div_start) begin
            r_div_neg <= sum_s[SUM_W-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide step");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.channel == CHAN_W'(CHANNELS - 1)))
        else $error("last flag on a channel other than the final one");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_len != '0)
        else $error("calibration length is zero");

    a_clear_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.mode == MODE_CLR_VEL) |=> (r_vel[0] == '0 && r_state == S_IDLE))
        else $error("velocity clear did not take effect");

    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.mode == MODE_SAMPLE) |=> (r_state == S_ACC && r_ch == '0))
        else $error("sample request did not start at the first channel");

endmodule
`default_nettype wire

@@ tb/imuoci_result_checker.sv @@
`default_nettype none
module imuoci_result_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire imuoci_pkg::t_in                   i_in_data,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire imuoci_pkg::t_out                  i_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [imuoci_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [imuoci_pkg::CFG_W-1:0]      i_cfg_data,
    output int                                     o_pending,
    output int                                     o_fail_count
);
    import imuoci_pkg::*;

    localparam int NCH  = CHANNELS_DEF;
    localparam int NACC = ACCEL_CHANNELS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic signed [95:0] TOP48 = 96'sh7FFF_FFFF_FFFF;
    localparam logic signed [95:0] BOT48 = -TOP48 - 96'sd1;

    logic [GAIN_W-1:0]         accel_gain, gyro_gain;
    logic [DECAY_W-1:0]        vel_decay, dist_decay;
    logic [CALIB_W-1:0]        cal_samples;
    logic signed [SAMPLE_W-1:0] offsets [NCH];
    logic [SUM_W-1:0]          cal_sums [NCH];
    int                        cal_countdown;
    int                        cal_len;
    logic signed [VAL_W-1:0]   velocity [NCH];
    logic signed [VAL_W-1:0]   distance [NCH];

    t_out due_results [$];
    int   mismatches = 0;

    function automatic logic signed [VAL_W-1:0] clamp48(input logic signed [95:0] x);
        if (x > TOP48) return TOP48[VAL_W-1:0];
        if (x < BOT48) return BOT48[VAL_W-1:0];
        return x[VAL_W-1:0];
    endfunction

    task automatic flag(input string what, input logic [VAL_W-1:0] got,
                        input logic [VAL_W-1:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (due_results.size() == 0) begin
            flag("result with no request pending", VAL_W'(got.channel), '0);
        end else begin
            want = due_results.pop_front();
            if (got.channel !== want.channel)
                flag("channel", VAL_W'(got.channel), VAL_W'(want.channel));
            if (got.accel_value !== want.accel_value)
                flag("accel_value", got.accel_value, want.accel_value);
            if (got.vel_value !== want.vel_value)
                flag("vel_value", got.vel_value, want.vel_value);
            if (got.dist_value !== want.dist_value)
                flag("dist_value", got.dist_value, want.dist_value);
            if (got.last !== want.last)
                flag("last", VAL_W'(got.last), VAL_W'(want.last));
        end
    endtask

    task automatic integrate_request(input t_in r);
        logic signed [SAMPLE_W-1:0] smp [NCH];
        logic signed [SAMPLE_W:0]   raw;
        logic signed [95:0]         a96, b96, wide;
        logic signed [VAL_W-1:0]    acc;
        logic [GAIN_W-1:0]          g;
        t_out                       res;
        longint                     q;
        smp[0] = r.sample_ax;
        smp[1] = r.sample_ay;
        smp[2] = r.sample_az;
        smp[3] = r.sample_gx;
        smp[4] = r.sample_gy;
        smp[5] = r.sample_gz;
        case (r.mode)
            MODE_CLR_VEL: begin
                for (int c = 0; c < NCH; c++) velocity[c] = '0;
            end
            MODE_CLR_DIST: begin
                for (int c = 0; c < NCH; c++) distance[c] = '0;
            end
            MODE_CAL_START: begin
                cal_len = (cal_samples == '0) ? 1 : int'(cal_samples);
                cal_countdown = cal_len;
                for (int c = 0; c < NCH; c++) cal_sums[c] = '0;
            end
            default: begin
                for (int c = 0; c < NCH; c++) begin
                    raw  = {smp[c][SAMPLE_W-1], smp[c]} - {offsets[c][SAMPLE_W-1], offsets[c]};
                    g    = (c < NACC) ? accel_gain : gyro_gain;
                    a96  = 96'(raw);
                    b96  = 96'(g);
                    acc  = clamp48(a96 * b96);
                    // leak products round toward minus infinity
                    a96  = 96'(velocity[c]);
                    b96  = 96'(vel_decay);
                    wide = (a96 * b96) >>> FRAC;
                    a96  = 96'(acc);
                    velocity[c] = clamp48(wide + a96);
                    a96  = 96'(distance[c]);
                    b96  = 96'(dist_decay);
                    wide = (a96 * b96) >>> FRAC;
                    a96  = 96'(velocity[c]);
                    distance[c] = clamp48(wide + a96);
                    res.channel     = CHAN_W'(c);
                    res.accel_value = acc;
                    res.vel_value   = velocity[c];
                    res.dist_value  = distance[c];
                    res.last        = (c == NCH - 1);
                    due_results.push_back(res);
                end
                if (cal_countdown > 0) begin
                    for (int c = 0; c < NCH; c++)
                        cal_sums[c] = cal_sums[c] + {{(SUM_W-SAMPLE_W){smp[c][SAMPLE_W-1]}}, smp[c]};
                    cal_countdown--;
                end else if (cal_countdown == 0) begin
                    // average truncates toward zero, then wraps into 16 bits
                    for (int c = 0; c < NCH; c++) begin
                        q = longint'($signed(cal_sums[c])) / longint'(cal_len);
                        offsets[c] = q[SAMPLE_W-1:0];
                    end
                    cal_countdown = -1;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            accel_gain    = GAIN_RST;
            gyro_gain     = GAIN_RST;
            vel_decay     = DECAY_RST;
            dist_decay    = DECAY_RST;
            cal_samples   = CALIB_RST;
            cal_countdown = -1;
            cal_len       = 1;
            for (int c = 0; c < NCH; c++) begin
                offsets[c]  = '0;
                cal_sums[c] = '0;
                velocity[c] = '0;
                distance[c] = '0;
            end
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    REG_ACCEL_GAIN:    accel_gain  = i_cfg_data[GAIN_W-1:0];
                    REG_GYRO_GAIN:     gyro_gain   = i_cfg_data[GAIN_W-1:0];
                    REG_VEL_DECAY:     vel_decay   = i_cfg_data[DECAY_W-1:0];
                    REG_DIST_DECAY:    dist_decay  = i_cfg_data[DECAY_W-1:0];
                    REG_CALIB_SAMPLES: cal_samples = i_cfg_data[CALIB_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) integrate_request(i_in_data);
        end
        o_pending    <= due_results.size();
        o_fail_count <= mismatches;
    end

endmodule
`default_nettype wire

@@ tb/imu_offset_calibrate_integrate_unit_tb.sv @@
`default_nettype none
module imu_offset_calibrate_integrate_unit_tb;
    import imuoci_pkg::*;

    localparam int SETTLE     = 400;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_REQS = 28;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int   pending;
    int   fail_count;
    int   idle_cycles = 0;
    bit   calm = 1'b0;
    int   cal_len_now = 64;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    imu_offset_calibrate_integrate_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    imuoci_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 18);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in req(input t_mode m, input logic [15:0] ax, ay, az, gx, gy, gz);
        t_in r;
        r.mode      = m;
        r.sample_ax = ax;
        r.sample_ay = ay;
        r.sample_az = az;
        r.sample_gx = gx;
        r.sample_gy = gy;
        r.sample_gz = gz;
        return r;
    endfunction

    function automatic logic [15:0] rand_reading();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in rand_sample();
        return req(MODE_SAMPLE, rand_reading(), rand_reading(), rand_reading(),
                   rand_reading(), rand_reading(), rand_reading());
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain();
        case ($urandom_range(5))
            0:       return GAIN_RST;
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom);
            default: return CFG_W'($urandom_range(0, 24'h03_0000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_decay();
        case ($urandom_range(6))
            0:       return CFG_W'(DECAY_RST);
            1:       return '0;
            2:       return 24'h1_FFFF;
            3:       return CFG_W'($urandom_range(0, 65536));
            default: return CFG_W'($urandom_range(60000, 65536));
        endcase
    endfunction

    // hold valid across back-to-back requests; drop it only for a gap
    task automatic send(input t_in r);
        if (!calm && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (!calm && $urandom_range(99) < 18);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] ag, gg, vd, dd, cs);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ACCEL_GAIN;
        cfg_data  <= ag;
        @(posedge clk);
        cfg_index <= REG_GYRO_GAIN;
        cfg_data  <= gg;
        @(posedge clk);
        cfg_index <= REG_VEL_DECAY;
        cfg_data  <= vd;
        @(posedge clk);
        cfg_index <= REG_DIST_DECAY;
        cfg_data  <= dd;
        @(posedge clk);
        cfg_index <= REG_CALIB_SAMPLES;
        cfg_data  <= cs;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cal_len_now = (cs[CALIB_W-1:0] == '0) ? 1 : int'(cs[CALIB_W-1:0]);
    endtask

    initial begin
        int sent;
        int runlen;
        t_mode m;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // unity gains and decays straight out of reset
        send(req(MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(req(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send(req(MODE_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send(req(MODE_SAMPLE, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA));
        send(req(MODE_CLR_VEL, 16'h1234, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        send(req(MODE_SAMPLE, 16'h0100, 16'hFF00, 16'h0010, 16'hFFF0, 16'h0001, 16'hFFFF));
        send(req(MODE_CLR_DIST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(req(MODE_SAMPLE, 16'h0100, 16'hFF00, 16'h0010, 16'hFFF0, 16'h0001, 16'hFFFF));
        drain_and_settle();

        // zero length runs as one sample; pull offsets to the negative extreme
        load_settings(24'hFF_FFFF, 24'h00_0000, 24'h0_0000, 24'h1_FFFF, 24'h00_0000);
        send(req(MODE_CAL_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(req(MODE_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send(req(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send(req(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send(req(MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000));
        drain_and_settle();

        // restarted calibration over three samples
        load_settings(24'h00_0000, 24'hFF_FFFF, 24'h1_0000, 24'h0_0000, 24'h00_0003);
        send(req(MODE_CAL_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(rand_sample());
        send(req(MODE_CAL_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(req(MODE_SAMPLE, 16'h0007, 16'hFFF9, 16'h7FFF, 16'h8000, 16'h0003, 16'hFFFD));
        send(req(MODE_SAMPLE, 16'h0002, 16'hFFFE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
        send(req(MODE_SAMPLE, 16'h0000, 16'h0000, 16'h7FFE, 16'h8001, 16'h0001, 16'hFFFF));
        send(rand_sample());
        send(rand_sample());

        for (int phase = 0; phase < 5; phase++) begin
            drain_and_settle();
            load_settings(rand_gain(), rand_gain(), rand_decay(), rand_decay(),
                          CFG_W'($urandom_range(0, 6)));
            calm = (phase == 2);
            sent = 0;
            while (sent < PHASE_REQS) begin
                if (phase == 1 && sent == PHASE_REQS / 2) begin
                    // hold off until every result is back
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                case ($urandom_range(99)) inside
                    [0:14]: begin
                        send(req(MODE_CAL_START, rand_reading(), rand_reading(), rand_reading(),
                                 rand_reading(), rand_reading(), rand_reading()));
                        // mostly complete runs, some cut short
                        runlen = ($urandom_range(4) == 0) ? $urandom_range(0, cal_len_now)
                                                          : cal_len_now + 1;
                        repeat (runlen) send(rand_sample());
                        sent += runlen + 1;
                    end
                    [15:19]: begin
                        send(req(MODE_CLR_VEL, rand_reading(), rand_reading(), rand_reading(),
                                 rand_reading(), rand_reading(), rand_reading()));
                        sent++;
                    end
                    [20:24]: begin
                        send(req(MODE_CLR_DIST, rand_reading(), rand_reading(), rand_reading(),
                                 rand_reading(), rand_reading(), rand_reading()));
                        sent++;
                    end
                    [25:29]: begin
                        m = t_mode'($urandom_range(3));
                        send(req(m, rand_reading(), rand_reading(), rand_reading(),
                                 rand_reading(), rand_reading(), rand_reading()));
                        sent++;
                    end
                    default: begin
                        send(rand_sample());
                        sent++;
                    end
                endcase
            end
            calm = 1'b0;
        end

        drain_and_settle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
src/imuoci_pkg.sv
src/imuoci_div.sv
src/imu_offset_calibrate_integrate_unit.sv
tb/imuoci_result_checker.sv
tb/imu_offset_calibrate_integrate_unit_tb.sv
